// ===== rtl/ptr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ptr_pkg
// Types and constants shared by the PI throttle regulator modules.
// ---------------------------------------------------------------------------
package ptr_pkg;

	localparam int unsigned SPEED_W = 16;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 2'd2;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd2077;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd128;
	localparam logic [SPEED_W-1:0] DRIVE_LIMIT_RST = 16'd11520;

	typedef struct packed {
		logic               restart;
		logic [SPEED_W-1:0] target_speed;
		logic [SPEED_W-1:0] measured_speed;
	} ptr_in_t;

	typedef struct packed {
		logic [SPEED_W-1:0] throttle;
		logic               clamped;
	} ptr_out_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [SPEED_W-1:0] drive_limit;
	} ptr_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/ptr_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ptr_core
// Control law and integrator state: error, saturating integral sum with
// conditional integration, PI sum and clamp to zero and the drive limit.
// ---------------------------------------------------------------------------
module ptr_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire ptr_pkg::ptr_in_t  item,
	input  wire ptr_pkg::ptr_cfg_t cfg,
	output      ptr_pkg::ptr_out_t result
);
	import ptr_pkg::*;

	logic signed [SUM_W-1:0] integral_sum_q;
	logic                    was_clamped_q;

	logic signed [SUM_W-1:0] sum_base;
	logic                    clamp_base;
	logic signed [16:0]      err;
	logic signed [SUM_W:0]   sum_wide;
	logic signed [SUM_W-1:0] sum_sat;
	logic signed [SUM_W-1:0] sum_new;
	logic signed [33:0]      prop;
	logic signed [48:0]      integ;
	logic signed [49:0]      total;
	logic signed [49:0]      limit_q16;
	logic                    clamp;
	logic [SPEED_W-1:0]      throttle;

	always_comb begin
		sum_base   = item.restart ? '0 : integral_sum_q;
		clamp_base = item.restart | was_clamped_q;
		err = $signed({1'b0, item.target_speed}) - $signed({1'b0, item.measured_speed});
		sum_wide = {sum_base[SUM_W-1], sum_base} + {{(SUM_W-16){err[16]}}, err};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
		sum_new = clamp_base ? sum_base : sum_sat;
		prop  = $signed({1'b0, cfg.prop_gain}) * err;
		integ = $signed({1'b0, cfg.integ_gain}) * sum_new;
		total = {{16{prop[33]}}, prop} + {integ[48], integ};
		limit_q16 = $signed({26'd0, cfg.drive_limit, 8'd0});
		if (total > limit_q16) begin
			throttle = cfg.drive_limit;
			clamp    = 1'b1;
		end else if (total[49]) begin
			throttle = '0;
			clamp    = 1'b1;
		end else begin
			throttle = total[23:8];
			clamp    = 1'b0;
		end
		result.throttle = throttle;
		result.clamped  = clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_sum_q <= '0;
			was_clamped_q  <= 1'b1;
		end else if (fire) begin
			integral_sum_q <= sum_new;
			was_clamped_q  <= clamp;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pi_throttle_regulator_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pi_throttle_regulator_unit
// PI throttle regulator with conditional-integration anti-windup.
// ---------------------------------------------------------------------------
// One item is taken per clock cycle unless the output stalls. The item is held
// in an input register, the control law is evaluated combinationally and the
// result is captured in an output register, from which it is presented.
// The throughput is set by the integrator feedback loop, in which the
// integral sum and clamp flag of one item are ready for the next item in the
// following cycle. A result waiting in the output register stalls the input
// only once the input register also holds an item. Configuration writes are
// accepted in every cycle and must be made only while the block is idle.
module pi_throttle_regulator_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire ptr_pkg::ptr_in_t            in_data,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      ptr_pkg::ptr_out_t           out_data,
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [ptr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ptr_pkg::GAIN_W-1:0]  cfg_data
);
	import ptr_pkg::*;

	ptr_cfg_t cfg_q;
	ptr_in_t  item_s1;
	logic     valid_s1;
	ptr_out_t result;
	ptr_out_t out_q;
	logic     out_valid_q;
	logic     advance;
	logic     fire;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= PROP_GAIN_RST;
			cfg_q.integ_gain  <= INTEG_GAIN_RST;
			cfg_q.drive_limit <= DRIVE_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data;
				CFG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data;
				CFG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			out_q <= result;
		end
	end

	ptr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clamped |->
			out_data.throttle == '0 || out_data.throttle == cfg_q.drive_limit)
		else $error("clamped result is neither zero nor the drive limit");

	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.clamped |-> out_data.throttle <= cfg_q.drive_limit)
		else $error("unclamped throttle exceeds the drive limit");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result produced without a held item");

endmodule
`default_nettype wire
